/* design/mcla_pkg.sv */
`default_nettype none

package mcla_pkg;

	localparam int COORD_W = 4;
	localparam int COST_W  = 9;
	localparam logic [COST_W-1:0] COST_CAP = '1;

	typedef enum logic [1:0] {
		LINE_ROW,
		LINE_COL,
		LINE_DIAG,
		LINE_ANTI
	} line_kind_t;

	typedef struct packed {
		logic               step;
		logic               use_bit;
		logic               last_bit;
		logic               last_mask;
		logic               last_line;
		line_kind_t         kind;
		logic [COORD_W-1:0] line_idx;
		logic [COORD_W-1:0] pos;
		logic [COORD_W-1:0] idx;
	} dp_step_t;

endpackage

`default_nettype wire

/* design/mcla_if.sv */
`default_nettype none

interface mcla_in_if;
	logic                          valid;
	logic                          ready;
	logic [mcla_pkg::COORD_W-1:0] stone_row;
	logic [mcla_pkg::COORD_W-1:0] stone_col;

	modport source (output valid, output stone_row, output stone_col, input ready);
	modport sink (input valid, input stone_row, input stone_col, output ready);
endinterface

interface mcla_out_if;
	logic                         valid;
	logic                         ready;
	logic [mcla_pkg::COST_W-1:0] min_moves;

	modport source (output valid, output min_moves, input ready);
	modport sink (input valid, input min_moves, output ready);
endinterface

`default_nettype wire

/* design/mcla_dp_ram.sv */
`default_nettype none

module mcla_dp_ram #(
	parameter int ADDR_W = 15,
	parameter int DATA_W = 9
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* design/mcla_seq.sv */
`default_nettype none

module mcla_seq #(
	parameter int MAX_STONES = 15
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [mcla_pkg::COORD_W-1:0]  n_eff,
	input  wire logic [MAX_STONES-1:0]         full,
	output mcla_pkg::dp_step_t                 step,
	output logic      [MAX_STONES-1:0]         mask,
	output logic      [MAX_STONES-1:0]         rd_addr
);

	localparam int IDX_W = (MAX_STONES > 1) ? $clog2(MAX_STONES) : 1;

	logic                          busy_q;
	mcla_pkg::line_kind_t          kind_q;
	logic [mcla_pkg::COORD_W-1:0] line_q;
	logic [MAX_STONES-1:0]         mask_q;
	logic [mcla_pkg::COORD_W-1:0] bit_q;
	logic [mcla_pkg::COORD_W-1:0] pos;
	logic [MAX_STONES-1:0]         bit_oh;
	logic [MAX_STONES-1:0]         top_mask;
	logic                          last_bit;
	logic                          last_mask;

	assign top_mask  = full - MAX_STONES'(1);
	assign last_bit  = (bit_q == n_eff - mcla_pkg::COORD_W'(1));
	assign last_mask = (mask_q == '0);

	always_comb begin
		pos = '0;
		for (int k = 0; k < MAX_STONES; k++) begin
			pos = pos + mcla_pkg::COORD_W'(mask_q[k]);
			bit_oh[k] = (bit_q == mcla_pkg::COORD_W'(k));
		end
	end

	always_comb begin
		step.step      = busy_q;
		step.use_bit   = ~mask_q[bit_q[IDX_W-1:0]];
		step.last_bit  = last_bit;
		step.last_mask = last_mask;
		step.last_line = (kind_q == mcla_pkg::LINE_ANTI);
		step.kind      = kind_q;
		step.line_idx  = line_q;
		step.pos       = pos;
		step.idx       = bit_q;
	end

	assign mask    = mask_q;
	assign rd_addr = mask_q | bit_oh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			kind_q <= mcla_pkg::LINE_ROW;
			line_q <= '0;
			mask_q <= '0;
			bit_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			kind_q <= mcla_pkg::LINE_ROW;
			line_q <= '0;
			mask_q <= top_mask;
			bit_q  <= '0;
		end else if (busy_q) begin
			if (!last_bit) begin
				bit_q <= bit_q + mcla_pkg::COORD_W'(1);
			end else begin
				bit_q <= '0;
				if (!last_mask) begin
					mask_q <= mask_q - MAX_STONES'(1);
				end else begin
					mask_q <= top_mask;
					unique case (kind_q)
						mcla_pkg::LINE_ROW: begin
							kind_q <= mcla_pkg::LINE_COL;
						end
						mcla_pkg::LINE_COL: begin
							if (line_q == n_eff - mcla_pkg::COORD_W'(1)) begin
								kind_q <= mcla_pkg::LINE_DIAG;
							end else begin
								kind_q <= mcla_pkg::LINE_ROW;
								line_q <= line_q + mcla_pkg::COORD_W'(1);
							end
						end
						mcla_pkg::LINE_DIAG: begin
							kind_q <= mcla_pkg::LINE_ANTI;
						end
						mcla_pkg::LINE_ANTI: begin
							busy_q <= 1'b0;
						end
						default: begin
							busy_q <= 1'b0;
						end
					endcase
				end
			end
		end
	end

endmodule

`default_nettype wire

/* design/mcla_eval.sv */
`default_nettype none

module mcla_eval #(
	parameter int MAX_STONES = 15
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic [mcla_pkg::COORD_W-1:0]          n_eff,
	input  wire logic [MAX_STONES-1:0]                 full,
	input  wire logic [MAX_STONES-1:0][7:0]            stones,
	input  mcla_pkg::dp_step_t                         step,
	input  wire logic [MAX_STONES-1:0]                 mask,
	input  wire logic [MAX_STONES-1:0]                 rd_addr,
	input  wire logic [mcla_pkg::COST_W-1:0]           rd_data,
	output logic                                       wr_en,
	output logic      [MAX_STONES-1:0]                 wr_addr,
	output logic      [mcla_pkg::COST_W-1:0]           wr_data,
	output logic                                       done,
	output logic      [mcla_pkg::COST_W-1:0]           result
);

	localparam int IDX_W = (MAX_STONES > 1) ? $clog2(MAX_STONES) : 1;

	mcla_pkg::dp_step_t            step_s1;
	logic [MAX_STONES-1:0]         mask_s1;
	logic [MAX_STONES-1:0]         addr_s1;
	logic [mcla_pkg::COST_W-1:0]  acc_q;
	logic [mcla_pkg::COST_W-1:0]  best_q;
	logic                          fwd_valid_q;
	logic [MAX_STONES-1:0]         fwd_addr_q;
	logic [mcla_pkg::COST_W-1:0]  fwd_data_q;

	logic [7:0]                    stone;
	logic [mcla_pkg::COORD_W-1:0] sr;
	logic [mcla_pkg::COORD_W-1:0] sc;
	logic [mcla_pkg::COORD_W-1:0] tr;
	logic [mcla_pkg::COORD_W-1:0] tc;
	logic [mcla_pkg::COORD_W-1:0] dr;
	logic [mcla_pkg::COORD_W-1:0] dc;
	logic [mcla_pkg::COST_W-1:0]  dp_val;
	logic [mcla_pkg::COST_W-1:0]  cost;
	logic [mcla_pkg::COST_W-1:0]  cand;
	logic [mcla_pkg::COST_W-1:0]  line_min;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1 <= '0;
		end else begin
			step_s1 <= step;
		end
	end

	always_ff @(posedge clk) begin
		mask_s1 <= mask;
		addr_s1 <= rd_addr;
	end

	always_comb begin
		stone = stones[step_s1.idx[IDX_W-1:0]];
		sr    = stone[7:4];
		sc    = stone[3:0];
		unique case (step_s1.kind)
			mcla_pkg::LINE_ROW: begin
				tr = step_s1.line_idx;
				tc = step_s1.pos;
			end
			mcla_pkg::LINE_COL: begin
				tr = step_s1.pos;
				tc = step_s1.line_idx;
			end
			mcla_pkg::LINE_DIAG: begin
				tr = step_s1.pos;
				tc = step_s1.pos;
			end
			mcla_pkg::LINE_ANTI: begin
				tr = step_s1.pos;
				tc = n_eff - step_s1.pos - mcla_pkg::COORD_W'(1);
			end
			default: begin
				tr = step_s1.pos;
				tc = step_s1.pos;
			end
		endcase
		dr = (sr > tr) ? sr - tr : tr - sr;
		dc = (sc > tc) ? sc - tc : tc - sc;

		// full mask costs nothing; a write at the edge of this read is forwarded
		priority if (addr_s1 == full) begin
			dp_val = '0;
		end else if (fwd_valid_q && addr_s1 == fwd_addr_q) begin
			dp_val = fwd_data_q;
		end else begin
			dp_val = rd_data;
		end

		cost = mcla_pkg::COST_W'(dr) + mcla_pkg::COST_W'(dc) + dp_val;
		cand = (step_s1.use_bit && cost < acc_q) ? cost : acc_q;
		line_min = (cand < best_q) ? cand : best_q;
	end

	assign wr_en   = step_s1.step && step_s1.last_bit;
	assign wr_addr = mask_s1;
	assign wr_data = cand;
	assign done    = wr_en && step_s1.last_mask && step_s1.last_line;
	assign result  = line_min;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= mcla_pkg::COST_CAP;
			best_q      <= mcla_pkg::COST_CAP;
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= wr_en;
			if (wr_en) begin
				acc_q <= mcla_pkg::COST_CAP;
				if (step_s1.last_mask) begin
					best_q <= step_s1.last_line ? mcla_pkg::COST_CAP : line_min;
				end
			end else if (step_s1.step) begin
				acc_q <= cand;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= mask_s1;
		fwd_data_q <= cand;
	end

endmodule

`default_nettype wire

/* design/min_cost_line_assignment.sv */
`default_nettype none

// Stones load one item per cycle while ready; the completing item starts the evaluation.
// Evaluation runs n * (2^n - 1) * (2n+2) dp steps, one per cycle through the dp RAM read
// port; the result register loads when the last step leaves the eval stage.
// No item is taken during evaluation; while a result waits, only a board's last item stalls.
// Reset (arst_n low) clears the stone count, board size (to 1) and control; the dp RAM
// and stone registers are not cleared.
module min_cost_line_assignment #(
	parameter int MAX_STONES = 15
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [mcla_pkg::COORD_W-1:0]  cfg_wr_data,
	mcla_in_if.sink                            stones,
	mcla_out_if.source                         result
);

	localparam int IDX_W = (MAX_STONES > 1) ? $clog2(MAX_STONES) : 1;

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

	state_t                                state_q;
	logic [mcla_pkg::COORD_W-1:0]          board_size_q;
	logic [mcla_pkg::COORD_W-1:0]          count_q;
	logic [MAX_STONES-1:0][7:0]            stone_q;
	logic                                  out_valid_q;
	logic [mcla_pkg::COST_W-1:0]           out_data_q;

	logic [mcla_pkg::COORD_W-1:0]          n_eff;
	logic [MAX_STONES-1:0]                 full;
	logic                                  completes;
	logic                                  accept;
	logic                                  start;

	mcla_pkg::dp_step_t                    step;
	logic [MAX_STONES-1:0]                 mask;
	logic [MAX_STONES-1:0]                 rd_addr;
	logic [mcla_pkg::COST_W-1:0]           rd_data;
	logic                                  wr_en;
	logic [MAX_STONES-1:0]                 wr_addr;
	logic [mcla_pkg::COST_W-1:0]           wr_data;
	logic                                  done;
	logic [mcla_pkg::COST_W-1:0]           eval_result;

	always_comb begin
		priority if (board_size_q == '0) begin
			n_eff = mcla_pkg::COORD_W'(1);
		end else if (board_size_q > mcla_pkg::COORD_W'(MAX_STONES)) begin
			n_eff = mcla_pkg::COORD_W'(MAX_STONES);
		end else begin
			n_eff = board_size_q;
		end
		for (int k = 0; k < MAX_STONES; k++) begin
			full[k] = (mcla_pkg::COORD_W'(k) < n_eff);
		end
	end

	assign completes = ({1'b0, count_q} + 5'd1) >= {1'b0, n_eff};
	assign stones.ready = (state_q == ST_IDLE) && (!out_valid_q || !completes);
	assign accept = stones.valid && stones.ready;
	assign start  = accept && completes;

	assign result.valid     = out_valid_q;
	assign result.min_moves = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_size_q <= mcla_pkg::COORD_W'(1);
		end else if (cfg_wr_en) begin
			board_size_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (completes) begin
							count_q <= '0;
							state_q <= ST_BUSY;
						end else begin
							count_q <= count_q + mcla_pkg::COORD_W'(1);
						end
					end
				end
				ST_BUSY: begin
					if (done) begin
						out_valid_q <= 1'b1;
						out_data_q  <= eval_result;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stone_q[count_q[IDX_W-1:0]] <= {stones.stone_row - mcla_pkg::COORD_W'(1),
				stones.stone_col - mcla_pkg::COORD_W'(1)};
		end
	end

	mcla_seq #(
		.MAX_STONES (MAX_STONES)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.n_eff   (n_eff),
		.full    (full),
		.step    (step),
		.mask    (mask),
		.rd_addr (rd_addr)
	);

	mcla_dp_ram #(
		.ADDR_W (MAX_STONES),
		.DATA_W (mcla_pkg::COST_W)
	) u_dp_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	mcla_eval #(
		.MAX_STONES (MAX_STONES)
	) u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.n_eff   (n_eff),
		.full    (full),
		.stones  (stone_q),
		.step    (step),
		.mask    (mask),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.done    (done),
		.result  (eval_result)
	);

endmodule

`default_nettype wire
